>>> sv/rcbu_pkg.sv
// ----------------------------------------------------------------------------
// rcbu_pkg: shared types and constants of the RGBA color blend unit
// Fixed-point widths, action and lane-kind codes, pipeline enable bundle.
// ----------------------------------------------------------------------------
package rcbu_pkg;

	// channel format: unsigned, CH_FRAC fraction bits, ONE stands for 1.0
	localparam int CH_FRAC   = 15;
	localparam int ONE       = 1 << CH_FRAC;
	localparam int HALF      = ONE / 2;
	localparam int CH_W      = 16;
	localparam int OUT_W     = 16;
	localparam int FACTOR_W  = 24;

	// multiplier operands and products
	localparam int RGB_SUM_W = CH_W + 2;
	localparam int A_W       = RGB_SUM_W + 1;
	localparam int B_W       = FACTOR_W;
	localparam int MIX_W     = CH_FRAC + 2;
	localparam int PROD_W    = A_W + B_W;
	localparam int SUM_W     = PROD_W + 1;

	// second multiplier stage
	localparam int X_W       = CH_FRAC + 2;
	localparam int M_W       = 2 * X_W;

	// amplitude: divide by 3*ONE as a shift then a reciprocal multiply by 1/3
	localparam int Q_W        = PROD_W - CH_FRAC;
	localparam int AMP_ROUND  = (3 * ONE) / 2;
	localparam int AMP_CLAMP  = 3 * (ONE + 1);
	localparam int AMP_SHIFT  = CH_FRAC + 3;
	localparam int AMP_RECIP  = ((1 << AMP_SHIFT) + 2) / 3;

	typedef enum logic [2:0] {
		ACT_AVERAGE   = 3'd0,
		ACT_ADD       = 3'd1,
		ACT_MULTIPLY  = 3'd2,
		ACT_SCALE     = 3'd3,
		ACT_FILTER    = 3'd4,
		ACT_MIX       = 3'd5,
		ACT_AMPLITUDE = 3'd6
	} action_t;

	// what a lane does with its two products
	typedef enum logic [2:0] {
		KIND_RAW,   // plain sum, saturated
		KIND_HALF,  // sum halved, truncating
		KIND_RND,   // sum rounded half up, negative to zero
		KIND_DUAL,  // each product rounded, then multiplied together
		KIND_AMP    // amplitude divide by 3*ONE
	} kind_t;

	typedef struct packed {
		logic signed [A_W-1:0] a0;
		logic signed [B_W-1:0] b0;
		logic signed [A_W-1:0] a1;
		logic signed [B_W-1:0] b1;
		kind_t                 kind;
	} lane_op_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

>>> sv/rcbu_lane.sv
// ----------------------------------------------------------------------------
// rcbu_lane: one channel datapath of the blend pipeline
// Operand register, product pair, combine/round, second multiply, saturate.
// ----------------------------------------------------------------------------
module rcbu_lane (
	input  logic                             clk,
	input  rcbu_pkg::pipe_en_t               en,
	input  rcbu_pkg::lane_op_t               op,
	output logic [rcbu_pkg::OUT_W-1:0]       res
);

	function automatic logic [rcbu_pkg::X_W-1:0] clip_one(
		input logic signed [rcbu_pkg::SUM_W-1:0] v
	);
		logic [rcbu_pkg::X_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > rcbu_pkg::SUM_W'(rcbu_pkg::ONE)) begin
			r = rcbu_pkg::X_W'(rcbu_pkg::ONE);
		end else begin
			r = v[rcbu_pkg::X_W-1:0];
		end
		return r;
	endfunction

	rcbu_pkg::lane_op_t                       op_s1;
	logic signed [rcbu_pkg::PROD_W-1:0]       p0_s2, p1_s2;
	rcbu_pkg::kind_t                          kind_s2, kind_s3;
	logic [rcbu_pkg::X_W-1:0]                 x_s3, y_s3;
	logic [rcbu_pkg::M_W-1:0]                 m_s4;
	logic                                     amp_s4;
	logic [rcbu_pkg::OUT_W-1:0]               res_s5;

	logic signed [rcbu_pkg::SUM_W-1:0]        sum_w, rnd_w;
	logic signed [rcbu_pkg::PROD_W-1:0]       r0_w, r1_w, qa_w;
	logic [rcbu_pkg::X_W-1:0]                 x_w, y_w;
	logic [rcbu_pkg::M_W:0]                   v_w;

	// stage 3: combine the product pair
	always_comb begin
		sum_w = rcbu_pkg::SUM_W'(p0_s2) + rcbu_pkg::SUM_W'(p1_s2);
		rnd_w = (sum_w + rcbu_pkg::SUM_W'(rcbu_pkg::HALF)) >>> rcbu_pkg::CH_FRAC;
		r0_w  = p0_s2 + rcbu_pkg::PROD_W'(rcbu_pkg::HALF);
		r1_w  = p1_s2 + rcbu_pkg::PROD_W'(rcbu_pkg::HALF);
		qa_w  = p0_s2 + rcbu_pkg::PROD_W'(rcbu_pkg::AMP_ROUND);
		y_w   = rcbu_pkg::X_W'(rcbu_pkg::ONE);
		case (kind_s2)
			rcbu_pkg::KIND_HALF: begin
				x_w = clip_one(sum_w >>> 1);
			end
			rcbu_pkg::KIND_RND: begin
				x_w = clip_one(rnd_w);
			end
			rcbu_pkg::KIND_DUAL: begin
				x_w = r0_w[rcbu_pkg::CH_FRAC+rcbu_pkg::X_W-1:rcbu_pkg::CH_FRAC];
				y_w = r1_w[rcbu_pkg::CH_FRAC+rcbu_pkg::X_W-1:rcbu_pkg::CH_FRAC];
			end
			rcbu_pkg::KIND_AMP: begin
				// quotient by ONE, clamped where the final result saturates anyway
				if (qa_w[rcbu_pkg::PROD_W-1:rcbu_pkg::CH_FRAC] >
						rcbu_pkg::Q_W'(rcbu_pkg::AMP_CLAMP)) begin
					x_w = rcbu_pkg::X_W'(rcbu_pkg::AMP_CLAMP);
				end else begin
					x_w = qa_w[rcbu_pkg::CH_FRAC+rcbu_pkg::X_W-1:rcbu_pkg::CH_FRAC];
				end
				y_w = rcbu_pkg::X_W'(rcbu_pkg::AMP_RECIP);
			end
			default: begin
				x_w = clip_one(sum_w);
			end
		endcase
	end

	// stage 5: final round (or reciprocal shift) and saturate
	always_comb begin
		if (amp_s4) begin
			v_w = (rcbu_pkg::M_W+1)'(m_s4 >> rcbu_pkg::AMP_SHIFT);
		end else begin
			v_w = ((rcbu_pkg::M_W+1)'(m_s4) + (rcbu_pkg::M_W+1)'(rcbu_pkg::HALF))
				>> rcbu_pkg::CH_FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1 <= op;
		end
		if (en.s2) begin
			p0_s2   <= op_s1.a0 * op_s1.b0;
			p1_s2   <= op_s1.a1 * op_s1.b1;
			kind_s2 <= op_s1.kind;
		end
		if (en.s3) begin
			x_s3    <= x_w;
			y_s3    <= y_w;
			kind_s3 <= kind_s2;
		end
		if (en.s4) begin
			m_s4   <= rcbu_pkg::M_W'(x_s3) * rcbu_pkg::M_W'(y_s3);
			amp_s4 <= (kind_s3 == rcbu_pkg::KIND_AMP);
		end
		if (en.s5) begin
			if (v_w > (rcbu_pkg::M_W+1)'(rcbu_pkg::ONE)) begin
				res_s5 <= rcbu_pkg::OUT_W'(rcbu_pkg::ONE);
			end else begin
				res_s5 <= v_w[rcbu_pkg::OUT_W-1:0];
			end
		end
	end

	assign res = res_s5;

endmodule

>>> sv/rgba_color_blend_unit.sv
// ----------------------------------------------------------------------------
// rgba_color_blend_unit: pipelined RGBA blend, Q1.15 channels, saturated out
// Pipeline: 5 register stages, s1 to s5; a result is offered from the s5
// output register after its input transfer has passed through s1 to s4.
// Throughput: one transfer per cycle; every stage takes a new transfer each
// cycle unless a stalled output holds the stages behind it.
// Reset: arst_n clears the stage valid bits only; data registers are free.
// ----------------------------------------------------------------------------
//
// Pipeline, per lane (red, green, blue, alpha):
//   s1  operand select: action decode, mix weight clamp, 1-Ab, rgb sum
//   s2  two signed products a0*b0 and a1*b1
//   s3  combine: sum, halve, round half up, per-product round, or amplitude quotient
//   s4  second multiply (multiply action, amplitude reciprocal, else x*ONE)
//   s5  final round / shift and saturation to [0, ONE]; output register
//
// Each stage advances when it is empty or the stage after it advances,
// so bubbles are squeezed out and a stalled output never drops a transfer.
// The amplitude action runs in the alpha lane; a flag travels with the
// valid bit to route that lane to the amplitude port instead of out_alpha.
module rgba_color_blend_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           action,
	input  logic [rcbu_pkg::CH_W-1:0]            a_red,
	input  logic [rcbu_pkg::CH_W-1:0]            a_green,
	input  logic [rcbu_pkg::CH_W-1:0]            a_blue,
	input  logic [rcbu_pkg::CH_W-1:0]            a_alpha,
	input  logic [rcbu_pkg::CH_W-1:0]            b_red,
	input  logic [rcbu_pkg::CH_W-1:0]            b_green,
	input  logic [rcbu_pkg::CH_W-1:0]            b_blue,
	input  logic [rcbu_pkg::CH_W-1:0]            b_alpha,
	input  logic signed [rcbu_pkg::FACTOR_W-1:0] factor,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rcbu_pkg::OUT_W-1:0]           out_red,
	output logic [rcbu_pkg::OUT_W-1:0]           out_green,
	output logic [rcbu_pkg::OUT_W-1:0]           out_blue,
	output logic [rcbu_pkg::OUT_W-1:0]           out_alpha,
	output logic [rcbu_pkg::OUT_W-1:0]           amplitude
);

	// zero-extend an unsigned value into a multiplier operand
	function automatic logic signed [rcbu_pkg::A_W-1:0] ext_a(
		input logic [rcbu_pkg::RGB_SUM_W-1:0] v
	);
		return $signed({1'b0, v});
	endfunction

	function automatic logic signed [rcbu_pkg::B_W-1:0] ext_b(
		input logic [rcbu_pkg::MIX_W-1:0] v
	);
		return $signed({{(rcbu_pkg::B_W-rcbu_pkg::MIX_W){1'b0}}, v});
	endfunction

	rcbu_pkg::pipe_en_t                   en;
	rcbu_pkg::lane_op_t                   ops [4];
	logic [rcbu_pkg::OUT_W-1:0]           res [4];
	logic [rcbu_pkg::CH_W-1:0]            ca  [4];
	logic [rcbu_pkg::CH_W-1:0]            cb  [4];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic amp_s1, amp_s2, amp_s3, amp_s4, amp_s5;

	logic [rcbu_pkg::MIX_W-1:0]           mix_w, one_m_w;
	logic signed [rcbu_pkg::B_W-1:0]      inv_ab_w, unit_w, one_w;
	logic [rcbu_pkg::RGB_SUM_W-1:0]       rgb_sum_w;

	// ------------------------------------------------------------------
	// Flow control: a stage loads when empty or when its successor loads.
	// ------------------------------------------------------------------
	always_comb begin
		en.s5 = !v_s5 || !out_stall;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// amplitude routing flag rides along with the data
	always_ff @(posedge clk) begin
		if (en.s1) amp_s1 <= (action == rcbu_pkg::ACT_AMPLITUDE);
		if (en.s2) amp_s2 <= amp_s1;
		if (en.s3) amp_s3 <= amp_s2;
		if (en.s4) amp_s4 <= amp_s3;
		if (en.s5) amp_s5 <= amp_s4;
	end

	// ------------------------------------------------------------------
	// Operand select. Lane 3 is alpha; ca/cb index 3 is the alpha channel.
	// ------------------------------------------------------------------
	always_comb begin
		ca[0] = a_red;
		ca[1] = a_green;
		ca[2] = a_blue;
		ca[3] = a_alpha;
		cb[0] = b_red;
		cb[1] = b_green;
		cb[2] = b_blue;
		cb[3] = b_alpha;

		// mix weight clamped to [0, ONE]
		if (factor < 0) begin
			mix_w = '0;
		end else if (factor > rcbu_pkg::FACTOR_W'(rcbu_pkg::ONE)) begin
			mix_w = rcbu_pkg::MIX_W'(rcbu_pkg::ONE);
		end else begin
			mix_w = factor[rcbu_pkg::MIX_W-1:0];
		end
		one_m_w   = rcbu_pkg::MIX_W'(rcbu_pkg::ONE) - mix_w;
		inv_ab_w  = rcbu_pkg::B_W'(rcbu_pkg::ONE) - $signed(rcbu_pkg::B_W'(b_alpha));
		unit_w    = rcbu_pkg::B_W'(1);
		one_w     = rcbu_pkg::B_W'(rcbu_pkg::ONE);
		rgb_sum_w = rcbu_pkg::RGB_SUM_W'(a_red) + rcbu_pkg::RGB_SUM_W'(a_green)
			+ rcbu_pkg::RGB_SUM_W'(a_blue);

		for (int i = 0; i < 4; i++) begin
			ops[i] = '{a0: '0, b0: '0, a1: '0, b1: '0, kind: rcbu_pkg::KIND_RAW};
		end

		unique case (rcbu_pkg::action_t'(action)) inside
			rcbu_pkg::ACT_AVERAGE: begin
				for (int i = 0; i < 4; i++) begin
					ops[i].a0   = ext_a(rcbu_pkg::RGB_SUM_W'(ca[i]));
					ops[i].b0   = unit_w;
					ops[i].a1   = ext_a(rcbu_pkg::RGB_SUM_W'(cb[i]));
					ops[i].b1   = unit_w;
					ops[i].kind = rcbu_pkg::KIND_HALF;
				end
			end
			rcbu_pkg::ACT_ADD, rcbu_pkg::ACT_MULTIPLY: begin
				// alpha-weighted colors; add sums, multiply rounds each first
				for (int i = 0; i < 3; i++) begin
					ops[i].a0   = ext_a(rcbu_pkg::RGB_SUM_W'(ca[i]));
					ops[i].b0   = ext_b(rcbu_pkg::MIX_W'(a_alpha));
					ops[i].a1   = ext_a(rcbu_pkg::RGB_SUM_W'(cb[i]));
					ops[i].b1   = ext_b(rcbu_pkg::MIX_W'(b_alpha));
					ops[i].kind = (action == rcbu_pkg::ACT_ADD) ?
						rcbu_pkg::KIND_RND : rcbu_pkg::KIND_DUAL;
				end
				ops[3].a0 = ext_a(rcbu_pkg::RGB_SUM_W'(a_alpha));
				if (action == rcbu_pkg::ACT_ADD) begin
					ops[3].b0   = unit_w;
					ops[3].a1   = ext_a(rcbu_pkg::RGB_SUM_W'(b_alpha));
					ops[3].b1   = unit_w;
					ops[3].kind = rcbu_pkg::KIND_RAW;
				end else begin
					ops[3].b0   = ext_b(rcbu_pkg::MIX_W'(b_alpha));
					ops[3].kind = rcbu_pkg::KIND_RND;
				end
			end
			rcbu_pkg::ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ops[i].a0 = ext_a(rcbu_pkg::RGB_SUM_W'(ca[i]));
					ops[i].b0 = unit_w;
				end
				// a non-positive factor gives a non-positive product: rounds to 0
				ops[3].a0   = ext_a(rcbu_pkg::RGB_SUM_W'(a_alpha));
				ops[3].b0   = factor;
				ops[3].kind = rcbu_pkg::KIND_RND;
			end
			rcbu_pkg::ACT_FILTER: begin
				// b over a: xb*ONE + (ONE - Ab)*xa, signed
				for (int i = 0; i < 3; i++) begin
					ops[i].a0   = ext_a(rcbu_pkg::RGB_SUM_W'(ca[i]));
					ops[i].b0   = inv_ab_w;
					ops[i].a1   = ext_a(rcbu_pkg::RGB_SUM_W'(cb[i]));
					ops[i].b1   = one_w;
					ops[i].kind = rcbu_pkg::KIND_RND;
				end
				ops[3].a0 = ext_a(rcbu_pkg::RGB_SUM_W'(a_alpha));
				ops[3].b0 = unit_w;
				ops[3].a1 = ext_a(rcbu_pkg::RGB_SUM_W'(b_alpha));
				ops[3].b1 = unit_w;
			end
			rcbu_pkg::ACT_MIX: begin
				for (int i = 0; i < 4; i++) begin
					ops[i].a0   = ext_a(rcbu_pkg::RGB_SUM_W'(ca[i]));
					ops[i].b0   = ext_b(mix_w);
					ops[i].a1   = ext_a(rcbu_pkg::RGB_SUM_W'(cb[i]));
					ops[i].b1   = ext_b(one_m_w);
					ops[i].kind = rcbu_pkg::KIND_RND;
				end
			end
			rcbu_pkg::ACT_AMPLITUDE: begin
				// color lanes stay zero; alpha lane computes the amplitude
				ops[3].a0   = ext_a(rgb_sum_w);
				ops[3].b0   = ext_b(rcbu_pkg::MIX_W'(a_alpha));
				ops[3].kind = rcbu_pkg::KIND_AMP;
			end
			default: begin
				// unused action code: all lanes produce zero
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Lanes
	// ------------------------------------------------------------------
	for (genvar g = 0; g < 4; g++) begin : g_lane
		rcbu_lane u_lane (
			.clk (clk),
			.en  (en),
			.op  (ops[g]),
			.res (res[g])
		);
	end

	assign out_valid = v_s5;
	assign out_red   = res[0];
	assign out_green = res[1];
	assign out_blue  = res[2];
	assign out_alpha = amp_s5 ? '0 : res[3];
	assign amplitude = amp_s5 ? res[3] : '0;

endmodule

>>> sv/rcbu_checker.sv
// ----------------------------------------------------------------------------
// rcbu_checker: port-level checks of the RGBA color blend unit
// Output hold under stall, saturation, amplitude routing and pipeline latency.
// ----------------------------------------------------------------------------
module rcbu_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [rcbu_pkg::OUT_W-1:0]           out_red,
	input logic [rcbu_pkg::OUT_W-1:0]           out_green,
	input logic [rcbu_pkg::OUT_W-1:0]           out_blue,
	input logic [rcbu_pkg::OUT_W-1:0]           out_alpha,
	input logic [rcbu_pkg::OUT_W-1:0]           amplitude
);

	// a stalled result keeps its valid and its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha) && $stable(amplitude))
		else $error("result changed while stalled");

	// every result field is saturated to ONE
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_red <= rcbu_pkg::OUT_W'(rcbu_pkg::ONE)
			&& out_green <= rcbu_pkg::OUT_W'(rcbu_pkg::ONE)
			&& out_blue <= rcbu_pkg::OUT_W'(rcbu_pkg::ONE)
			&& out_alpha <= rcbu_pkg::OUT_W'(rcbu_pkg::ONE)
			&& amplitude <= rcbu_pkg::OUT_W'(rcbu_pkg::ONE))
		else $error("result above saturation ceiling");

	// a nonzero amplitude only comes with zero color fields
	a_amp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && amplitude != '0 |-> out_red == '0 && out_green == '0
			&& out_blue == '0 && out_alpha == '0)
		else $error("amplitude and color both nonzero");

	// with the output free, an accepted transfer passes s1 to s5 and shows as out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
			##1 !out_stall |=> out_valid)
		else $error("transfer lost in pipeline");

	// no input transfer is refused while the output side is free
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with output free");

endmodule

bind rgba_color_blend_unit rcbu_checker u_rcbu_checker (.*);

>>> tb/tb_rgba_color_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_rgba_color_blend_unit: self-checking regression of the RGBA blend unit
// A table of corner rows, then random pixel pairs, are sent in random bursts
// against a receiver that stalls on its own pattern, with one long hold-off.
// Every result is checked field by field against a typed-in result or an in-bench blend predictor.
// ----------------------------------------------------------------------------
module tb_rgba_color_blend_unit;

	// action code with no operation behind it: all result fields read zero
	localparam logic [2:0]  ACT_UNUSED   = 3'd7;

	localparam logic [15:0] C0           = 16'd0;
	localparam logic [15:0] C1           = 16'(rcbu_pkg::ONE);
	localparam logic [15:0] CM           = 16'hFFFF;
	localparam logic [23:0] F0           = 24'd0;

	localparam int          N_DIRECTED   = 23;
	localparam int          N_RANDOM     = 630;
	localparam int          HOLD_AFTER   = 250;  // results seen before the hold-off
	localparam int          HOLD_CYCLES  = 80;
	localparam int          DRAIN_CYCLES = 20;   // well past the pipeline latency
	localparam int          IDLE_LIMIT   = 2000;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic [15:0] amp;
	} blend_out_t;

	// one pixel pair plus, for typed table rows, a result typed in by hand
	typedef struct packed {
		logic [2:0]         action;
		logic [15:0]        a_red;
		logic [15:0]        a_green;
		logic [15:0]        a_blue;
		logic [15:0]        a_alpha;
		logic [15:0]        b_red;
		logic [15:0]        b_green;
		logic [15:0]        b_blue;
		logic [15:0]        b_alpha;
		logic signed [23:0] factor;
		logic               typed;
		blend_out_t         want;
	} pixel_job_t;

	typedef enum logic [1:0] {
		RX_FLOWING,
		RX_SPARSE,
		RX_PERIODIC,
		RX_HEAVY
	} rx_mode_t;

	// Corner rows. Rows with typed set carry their result; the rest go
	// through the predictor like the random part.
	localparam pixel_job_t DIRECTED [N_DIRECTED] = '{
		// average: zeros, full-scale inputs saturate, odd sum truncates
		'{rcbu_pkg::ACT_AVERAGE, C0, C0, C0, C0, C0, C0, C0, C0, F0, 1'b1,
			'{C0, C0, C0, C0, C0}},
		'{rcbu_pkg::ACT_AVERAGE, CM, CM, CM, CM, CM, CM, CM, CM, F0, 1'b1,
			'{C1, C1, C1, C1, C0}},
		'{rcbu_pkg::ACT_AVERAGE, CM, CM, CM, CM, C0, C0, C0, C0, F0, 1'b0, '0},
		// add: unit inputs overflow to ONE, zero alpha kills the color
		'{rcbu_pkg::ACT_ADD, C1, C1, C1, C1, C1, C1, C1, C1, F0, 1'b1,
			'{C1, C1, C1, C1, C0}},
		'{rcbu_pkg::ACT_ADD, C1, C1, C1, C0, C1, C1, C1, C0, F0, 1'b1,
			'{C0, C0, C0, C0, C0}},
		'{rcbu_pkg::ACT_ADD, 16'd1000, 16'd20000, C1, 16'd16384,
			16'd30000, 16'd500, 16'd7, 16'd24576, F0, 1'b0, '0},
		// multiply
		'{rcbu_pkg::ACT_MULTIPLY, C1, C1, C1, C1, C1, C1, C1, C1, F0, 1'b1,
			'{C1, C1, C1, C1, C0}},
		'{rcbu_pkg::ACT_MULTIPLY, CM, 16'd12345, C1, CM, CM, 16'd1, 16'd2, CM, F0,
			1'b0, '0},
		// scale: negative and zero factor clear alpha, huge factor saturates
		'{rcbu_pkg::ACT_SCALE, 16'd100, 16'd200, 16'd300, C1, CM, CM, CM, CM,
			24'hFFFFFF, 1'b1, '{16'd100, 16'd200, 16'd300, C0, C0}},
		'{rcbu_pkg::ACT_SCALE, 16'd111, 16'd222, 16'd333, CM, C0, C0, C0, C0, F0,
			1'b1, '{16'd111, 16'd222, 16'd333, C0, C0}},
		'{rcbu_pkg::ACT_SCALE, CM, C0, C1, C1, C0, C0, C0, C0, 24'h7FFFFF, 1'b1,
			'{C1, C0, C1, C1, C0}},
		'{rcbu_pkg::ACT_SCALE, 16'd4321, C1, 16'd9, C1, C0, C0, C0, C0, 24'd16384,
			1'b0, '0},
		// filter: b alpha above ONE drives the sum negative, clamps to zero
		'{rcbu_pkg::ACT_FILTER, C1, C1, C1, C1, C0, C0, C0, CM, F0, 1'b1,
			'{C0, C0, C0, C1, C0}},
		'{rcbu_pkg::ACT_FILTER, CM, CM, CM, C0, 16'd5, CM, 16'd20000, C1, F0, 1'b0, '0},
		'{rcbu_pkg::ACT_FILTER, 16'd8000, 16'd30000, C1, 16'd100,
			16'd3, 16'd16000, 16'd777, 16'd9999, F0, 1'b0, '0},
		// mix: factor clamps at both ends, then a mid weight
		'{rcbu_pkg::ACT_MIX, 16'd10, 16'd20, 16'd30, 16'd40, CM, 16'd5000, C1, C0,
			24'h800000, 1'b0, '0},
		'{rcbu_pkg::ACT_MIX, 16'd10, CM, 16'd30, C1, CM, 16'd5000, C1, C0,
			24'h7FFFFF, 1'b0, '0},
		'{rcbu_pkg::ACT_MIX, 16'd1, 16'd32767, CM, 16'd12000, 16'd2, C0, 16'd5,
			16'd30000, 24'd16384, 1'b0, '0},
		// amplitude: colors read zero, amplitude saturates on large channels
		'{rcbu_pkg::ACT_AMPLITUDE, C1, C1, C1, C1, CM, CM, CM, CM, 24'h123456, 1'b1,
			'{C0, C0, C0, C0, C1}},
		'{rcbu_pkg::ACT_AMPLITUDE, CM, CM, CM, CM, C0, C0, C0, C0, F0, 1'b0, '0},
		'{rcbu_pkg::ACT_AMPLITUDE, C0, C0, C0, C0, C1, C1, C1, C1, F0, 1'b1,
			'{C0, C0, C0, C0, C0}},
		'{rcbu_pkg::ACT_AMPLITUDE, 16'd1, C0, C0, 16'd1, C0, C0, C0, C0, F0, 1'b0, '0},
		// unused code: everything zero whatever the operands
		'{ACT_UNUSED, CM, CM, CM, CM, CM, CM, CM, CM, 24'h7FFFFF, 1'b1,
			'{C0, C0, C0, C0, C0}}
	};

	logic        clk = 1'b0;
	logic        arst_n;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = '0;
	logic [15:0] a_red = '0;
	logic [15:0] a_green = '0;
	logic [15:0] a_blue = '0;
	logic [15:0] a_alpha = '0;
	logic [15:0] b_red = '0;
	logic [15:0] b_green = '0;
	logic [15:0] b_blue = '0;
	logic [15:0] b_alpha = '0;
	logic signed [23:0] factor = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic [15:0] out_alpha;
	logic [15:0] amplitude;

	pixel_job_t  pixel_jobs [$];      // everything to send, table rows first
	blend_out_t  pending_blends [$];  // predicted results, oldest first

	int          jobs_sent = 0;
	int          blends_checked = 0;
	int          mismatches = 0;
	int          action_count [8];
	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          mode_left = 0;
	int          rx_tick = 0;
	rx_mode_t    rx_mode = RX_FLOWING;
	int          quiet_cycles = 0;
	pixel_job_t  sent_job;
	pixel_job_t  next_job;
	blend_out_t  oldest_blend;
	logic        stall_next;

	rgba_color_blend_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.a_red     (a_red),
		.a_green   (a_green),
		.a_blue    (a_blue),
		.a_alpha   (a_alpha),
		.b_red     (b_red),
		.b_green   (b_green),
		.b_blue    (b_blue),
		.b_alpha   (b_alpha),
		.factor    (factor),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.amplitude (amplitude)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Blend predictor. Products are held in 64 bits, so nothing wraps
	// before the final saturation to [0, ONE].
	// ------------------------------------------------------------------

	// round half up; zero or negative sums give zero
	function automatic longint round_q(longint p);
		if (p <= 0)
			return 0;
		return (p + rcbu_pkg::HALF) >>> rcbu_pkg::CH_FRAC;
	endfunction

	function automatic logic [15:0] clamp_channel(longint v);
		if (v < 0)
			return '0;
		if (v > rcbu_pkg::ONE)
			return 16'(rcbu_pkg::ONE);
		return v[15:0];
	endfunction

	function automatic blend_out_t blend_pixels(pixel_job_t j);
		longint     ca [4];
		longint     cb [4];
		longint     res [4];
		longint     f;
		longint     m;
		longint     amp;
		int         i;
		blend_out_t o;
		ca[0] = j.a_red;
		ca[1] = j.a_green;
		ca[2] = j.a_blue;
		ca[3] = j.a_alpha;
		cb[0] = j.b_red;
		cb[1] = j.b_green;
		cb[2] = j.b_blue;
		cb[3] = j.b_alpha;
		f = j.factor;
		amp = 0;
		for (i = 0; i < 4; i++)
			res[i] = 0;
		case (j.action)
			rcbu_pkg::ACT_AVERAGE: begin
				for (i = 0; i < 4; i++)
					res[i] = (ca[i] + cb[i]) >>> 1;
			end
			rcbu_pkg::ACT_ADD: begin
				for (i = 0; i < 3; i++)
					res[i] = round_q(ca[i] * ca[3] + cb[i] * cb[3]);
				res[3] = ca[3] + cb[3];
			end
			rcbu_pkg::ACT_MULTIPLY: begin
				for (i = 0; i < 3; i++)
					res[i] = round_q(round_q(ca[i] * ca[3]) * round_q(cb[i] * cb[3]));
				res[3] = round_q(ca[3] * cb[3]);
			end
			rcbu_pkg::ACT_SCALE: begin
				for (i = 0; i < 3; i++)
					res[i] = ca[i];
				res[3] = (f > 0) ? round_q(ca[3] * f) : 0;
			end
			rcbu_pkg::ACT_FILTER: begin
				for (i = 0; i < 3; i++)
					res[i] = round_q(cb[i] * rcbu_pkg::ONE
						+ (rcbu_pkg::ONE - cb[3]) * ca[i]);
				res[3] = ca[3] + cb[3];
			end
			rcbu_pkg::ACT_MIX: begin
				m = (f < 0) ? 0 : ((f > rcbu_pkg::ONE) ? longint'(rcbu_pkg::ONE) : f);
				for (i = 0; i < 4; i++)
					res[i] = round_q(ca[i] * m + cb[i] * (rcbu_pkg::ONE - m));
			end
			rcbu_pkg::ACT_AMPLITUDE: begin
				amp = ((ca[0] + ca[1] + ca[2]) * ca[3] + (3 * rcbu_pkg::ONE) / 2)
					/ (3 * rcbu_pkg::ONE);
			end
			default: ;
		endcase
		o.red   = clamp_channel(res[0]);
		o.green = clamp_channel(res[1]);
		o.blue  = clamp_channel(res[2]);
		o.alpha = clamp_channel(res[3]);
		o.amp   = clamp_channel(amp);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Random pixel pairs: mostly legal Q1.15 channels, with a share of
	// extremes and full 16-bit values so every input bit toggles.
	// ------------------------------------------------------------------
	function automatic logic [15:0] random_channel();
		case ($urandom_range(0, 9))
			0:       return C0;
			1:       return C1;
			2:       return CM;
			3, 4:    return 16'($urandom);
			default: return 16'($urandom_range(0, rcbu_pkg::ONE));
		endcase
	endfunction

	function automatic pixel_job_t random_job();
		pixel_job_t j;
		j = '0;
		if ($urandom_range(0, 15) == 0)
			j.action = ACT_UNUSED;
		else
			j.action = 3'($urandom_range(0, 6));
		j.a_red   = random_channel();
		j.a_green = random_channel();
		j.a_blue  = random_channel();
		j.a_alpha = random_channel();
		j.b_red   = random_channel();
		j.b_green = random_channel();
		j.b_blue  = random_channel();
		j.b_alpha = random_channel();
		// factor: inside [0,1], above 1, negative, full range, both extremes
		case ($urandom_range(0, 7))
			0:       j.factor = '0;
			1:       j.factor = 24'(rcbu_pkg::ONE);
			2:       j.factor = 24'($urandom_range(0, rcbu_pkg::ONE));
			3, 4:    j.factor = 24'($urandom_range(0, 2 * rcbu_pkg::ONE));
			5:       j.factor = 24'(-int'($urandom_range(1, rcbu_pkg::ONE)));
			6:       j.factor = 24'($urandom);
			default: j.factor = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
		endcase
		return j;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps. A transfer the
	// block has not taken yet stays put, payload and all. The result of
	// each accepted transfer is queued at the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sent_job = pixel_jobs[jobs_sent];
				pending_blends.push_back(sent_job.typed ? sent_job.want
					: blend_pixels(sent_job));
				action_count[sent_job.action]++;
				jobs_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: gap_left = 0;
						8, 9:       gap_left = $urandom_range(5, 25);
						default:    gap_left = $urandom_range(1, 4);
					endcase
				end
				if (burst_left != 0 && jobs_sent < pixel_jobs.size()) begin
					next_job = pixel_jobs[jobs_sent];
					action   <= next_job.action;
					a_red    <= next_job.a_red;
					a_green  <= next_job.a_green;
					a_blue   <= next_job.a_blue;
					a_alpha  <= next_job.a_alpha;
					b_red    <= next_job.b_red;
					b_green  <= next_job.b_green;
					b_blue   <= next_job.b_blue;
					b_alpha  <= next_job.b_alpha;
					factor   <= next_job.factor;
					in_valid <= 1'b1;
					burst_left--;
				end else begin
					in_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: checks each result transfer against the oldest prediction,
	// then picks next cycle's stall. The stall mode changes at random
	// intervals; once, mid-run, it holds off long enough for the
	// pipeline to fill and push back on the sender.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_blends.size() == 0) begin
					$error("result transfer with no blend pending");
					mismatches++;
				end else begin
					oldest_blend = pending_blends.pop_front();
					check_field("out_red", oldest_blend.red, out_red);
					check_field("out_green", oldest_blend.green, out_green);
					check_field("out_blue", oldest_blend.blue, out_blue);
					check_field("out_alpha", oldest_blend.alpha, out_alpha);
					check_field("amplitude", oldest_blend.amp, amplitude);
					blends_checked++;
				end
			end
			rx_tick++;
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && blends_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (rx_mode)
					RX_FLOWING:  stall_next = 1'b0;
					RX_SPARSE:   stall_next = ($urandom_range(0, 3) == 0);
					RX_PERIODIC: stall_next = (rx_tick % 3 == 0);
					default:     stall_next = ($urandom_range(0, 9) < 7);
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// watchdog: a stretch with no transfer on either side means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$error("no transfer for %0d cycles, %0d of %0d pairs sent, %0d pending",
					IDLE_LIMIT, jobs_sent, pixel_jobs.size(), pending_blends.size());
				$display("rgba_color_blend_unit regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Run control: build the stimulus, reset once, wait for the last
	// result, drain past the latency, report.
	// ------------------------------------------------------------------
	initial begin
		int k;
		arst_n = 1'b0;
		for (k = 0; k < 8; k++)
			action_count[k] = 0;
		for (k = 0; k < N_DIRECTED; k++)
			pixel_jobs.push_back(DIRECTED[k]);
		for (k = 0; k < N_RANDOM; k++)
			pixel_jobs.push_back(random_job());
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (jobs_sent == pixel_jobs.size() && pending_blends.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d pixel pairs (%0d corner rows, %0d random), checked %0d blends",
			jobs_sent, N_DIRECTED, N_RANDOM, blends_checked);
		$display("per action avg/add/mul/scale/filter/mix/amp/unused: %0d %0d %0d %0d %0d %0d %0d %0d",
			action_count[0], action_count[1], action_count[2], action_count[3],
			action_count[4], action_count[5], action_count[6], action_count[7]);
		if (mismatches == 0 && pending_blends.size() == 0)
			$display("rgba_color_blend_unit regression: pass");
		else
			$display("rgba_color_blend_unit regression: fail");
		$finish;
	end

endmodule

>>> sim.f
sv/rcbu_pkg.sv
sv/rcbu_lane.sv
sv/rgba_color_blend_unit.sv
sv/rcbu_checker.sv
tb/tb_rgba_color_blend_unit.sv
